// ===== hdl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants for the FR-FCFS DRAM scheduler core.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int ADDR_W  = 32;
    localparam int ROW_W   = 16;
    localparam int CYC_W   = 10;
    localparam int HOLD_W  = 4;
    localparam int KIND_W  = 2;
    localparam int BANKID_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_ENQ     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_CYC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_CYC      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_CYC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_DELAY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_HOLD     = 3'd6;

    localparam logic [CYC_W-1:0]  RST_CLOSED_CYC   = 10'd249;
    localparam logic [CYC_W-1:0]  RST_HIT_CYC      = 10'd149;
    localparam logic [CYC_W-1:0]  RST_MISS_CYC     = 10'd349;
    localparam logic [CYC_W-1:0]  RST_CLOSED_DELAY = 10'd200;
    localparam logic [CYC_W-1:0]  RST_HIT_DELAY    = 10'd100;
    localparam logic [CYC_W-1:0]  RST_MISS_DELAY   = 10'd300;
    localparam logic [HOLD_W-1:0] RST_CMD_HOLD     = 4'd4;

    typedef enum logic [1:0] {
        RS_CLOSED = 2'd0,
        RS_HIT    = 2'd1,
        RS_MISS   = 2'd2
    } row_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BANK,
        ST_DEC,
        ST_SCAN,
        ST_ISSUE
    } ctrl_state_t;

    typedef struct packed {
        logic enq;        // accept an enqueue and load its answer
        logic idx_clr;    // restart the shared index counter
        logic bank_sel;   // bank port addressed by the index counter
        logic bank_step;  // examine one bank, free it if its count is zero
        logic dec;        // count down bank and bus timers
        logic scan_step;  // examine one queue entry
        logic pick_sel;   // queue port addressed by the chosen entry
        logic issue;      // issue the chosen request and load the summary
    } dfs_cmd_t;

    typedef struct packed {
        logic bank_done;  // examined bank completes on this tick
        logic bank_last;  // examined bank is the highest one
        logic scan_last;  // examined entry is the last queue slot
    } dfs_status_t;

endpackage

// ===== hdl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer: accepts items, walks banks and queue entries for a tick and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module dfs_ctrl
    import dfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    output logic        out_valid,
    input  logic        out_ready,
    input  dfs_status_t status,
    output dfs_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;
    logic        load;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    if (op == OP_ENQ)
                    begin
                        cmd.enq = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_BANK;
                    end
                end
            end
            ST_BANK:
            begin
                cmd.bank_sel = 1'b1;
                // A completing bank needs the output register; others pass freely.
                if (!status.bank_done || slot_free)
                begin
                    cmd.bank_step = 1'b1;
                    if (status.bank_last)
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC:
            begin
                cmd.dec     = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.pick_sel = 1'b1;
                if (slot_free)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load = cmd.enq || cmd.issue || (cmd.bank_step && status.bank_done);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

endmodule

// ===== hdl/dfs_datapath.sv =====
// ----------------------------------------------------------------------------
// dfs_datapath
// Request queue, bank state, bus timers, configuration registers and the
// output register of the scheduler.
// ----------------------------------------------------------------------------
module dfs_datapath
    import dfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int BANK_COUNT  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dfs_cmd_t             cmd,
    output dfs_status_t          status,
    input  logic [ADDR_W-1:0]    addr,
    input  logic                 stage,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CYC_W-1:0]     cfg_data,
    output logic [KIND_W-1:0]    kind,
    output logic                 refused,
    output logic [BANKID_W-1:0]  bank_id,
    output logic [ROW_W-1:0]     row_id,
    output logic [CYC_W-1:0]     mem_stall,
    output logic [CYC_W-1:0]     fetch_stall,
    output logic                 issued,
    output logic                 last
);

    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int BW    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int MAXN  = (QUEUE_DEPTH > BANK_COUNT) ? QUEUE_DEPTH : BANK_COUNT;
    localparam int IW    = $clog2(MAXN);
    localparam logic [4:0]    BC5       = 5'(BANK_COUNT);
    localparam logic [CW-1:0] Q_FULL    = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] BANK_LAST = IW'(BANK_COUNT - 1);
    localparam logic [IW-1:0] Q_LAST    = IW'(QUEUE_DEPTH - 1);

    // Configuration.
    logic [CYC_W-1:0]  cycles_reg [3];
    logic [CYC_W-1:0]  delay_reg  [3];
    logic [HOLD_W-1:0] hold_reg;

    // Queue storage; entries at and above the fill count are don't-care.
    logic [BW-1:0]    q_bank_reg  [QUEUE_DEPTH];
    logic [ROW_W-1:0] q_row_reg   [QUEUE_DEPTH];
    logic             q_stage_reg [QUEUE_DEPTH];
    logic [CW-1:0]    count_reg;

    // Bank state: an active bank holds a busy count, an idle one does not.
    logic             busy_act_reg [BANK_COUNT];
    logic [CYC_W-1:0] busy_cnt_reg [BANK_COUNT];
    logic             open_reg     [BANK_COUNT];
    logic [ROW_W-1:0] open_row_reg [BANK_COUNT];

    logic [HOLD_W-1:0] cmd_timer_reg;
    logic [CYC_W-1:0]  data_timer_reg;
    logic [IW-1:0]     idx_reg;

    // Scan results.
    logic             any_reg;
    logic             first_found_reg, hit_found_reg;
    logic [QW-1:0]    first_idx_reg, hit_idx_reg;
    row_state_t       first_st_reg;

    // Output register payload.
    logic [KIND_W-1:0]   kind_reg;
    logic                refused_reg;
    logic [BANKID_W-1:0] bank_id_reg;
    logic [ROW_W-1:0]    row_id_reg;
    logic [CYC_W-1:0]    mem_stall_reg, fetch_stall_reg;
    logic                issued_reg, last_reg;

    logic [4:0]       enq_bank5;
    logic [BW-1:0]    enq_bank;
    logic [QW-1:0]    q_addr;
    logic [BW-1:0]    rd_bank;
    logic [BW-1:0]    e_bank;
    logic [ROW_W-1:0] e_row;
    logic             e_stage;
    row_state_t       e_st;
    logic             e_can;
    logic             e_valid;
    logic             pick_found;
    row_state_t       pick_st;
    logic [CYC_W-1:0] pick_cyc;

    // Bank bits wrap modulo the bank count; at most four subtractions on 3 bits.
    always_comb
    begin
        enq_bank5 = {2'b00, addr[7:5]};
        for (int k = 0; k < 4; k++)
        begin
            if (enq_bank5 >= BC5)
            begin
                enq_bank5 = enq_bank5 - BC5;
            end
        end
        enq_bank = enq_bank5[BW-1:0];
    end

    assign pick_found = hit_found_reg || first_found_reg;
    assign pick_st    = hit_found_reg ? RS_HIT : first_st_reg;
    assign q_addr     = cmd.pick_sel ? (hit_found_reg ? hit_idx_reg : first_idx_reg)
                                     : idx_reg[QW-1:0];
    assign e_bank     = q_bank_reg[q_addr];
    assign e_row      = q_row_reg[q_addr];
    assign e_stage    = q_stage_reg[q_addr];
    assign rd_bank    = cmd.bank_sel ? idx_reg[BW-1:0] : e_bank;
    assign e_valid    = CW'(idx_reg) < count_reg;
    assign pick_cyc   = cycles_reg[pick_st];

    always_comb
    begin
        if (!open_reg[rd_bank])
        begin
            e_st = RS_CLOSED;
        end
        else if (open_row_reg[rd_bank] == e_row)
        begin
            e_st = RS_HIT;
        end
        else
        begin
            e_st = RS_MISS;
        end
        e_can = !busy_act_reg[rd_bank] && (cmd_timer_reg == '0)
                && (delay_reg[e_st] > data_timer_reg);
    end

    assign status.bank_done = busy_act_reg[rd_bank] && (busy_cnt_reg[rd_bank] == '0);
    assign status.bank_last = idx_reg == BANK_LAST;
    assign status.scan_last = idx_reg == Q_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg[0] <= RST_CLOSED_CYC;
            cycles_reg[1] <= RST_HIT_CYC;
            cycles_reg[2] <= RST_MISS_CYC;
            delay_reg[0]  <= RST_CLOSED_DELAY;
            delay_reg[1]  <= RST_HIT_DELAY;
            delay_reg[2]  <= RST_MISS_DELAY;
            hold_reg      <= RST_CMD_HOLD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CLOSED_CYC:   cycles_reg[0] <= cfg_data;
                CFG_HIT_CYC:      cycles_reg[1] <= cfg_data;
                CFG_MISS_CYC:     cycles_reg[2] <= cfg_data;
                CFG_CLOSED_DELAY: delay_reg[0]  <= cfg_data;
                CFG_HIT_DELAY:    delay_reg[1]  <= cfg_data;
                CFG_MISS_DELAY:   delay_reg[2]  <= cfg_data;
                CFG_CMD_HOLD:     hold_reg      <= cfg_data[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control state: fill count, timers, bank activity, index and scan flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            cmd_timer_reg   <= '0;
            data_timer_reg  <= '0;
            idx_reg         <= '0;
            any_reg         <= 1'b0;
            first_found_reg <= 1'b0;
            hit_found_reg   <= 1'b0;
            for (int b = 0; b < BANK_COUNT; b++)
            begin
                busy_act_reg[b] <= 1'b0;
                open_reg[b]     <= 1'b0;
            end
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.bank_step || cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.enq && count_reg != Q_FULL)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.bank_step && status.bank_done)
            begin
                busy_act_reg[rd_bank] <= 1'b0;
            end

            if (cmd.dec)
            begin
                if (cmd_timer_reg != '0)
                begin
                    cmd_timer_reg <= cmd_timer_reg - 1'b1;
                end
                if (data_timer_reg != '0)
                begin
                    data_timer_reg <= data_timer_reg - 1'b1;
                end
                any_reg         <= 1'b0;
                first_found_reg <= 1'b0;
                hit_found_reg   <= 1'b0;
            end

            if (cmd.scan_step && e_valid)
            begin
                any_reg <= 1'b1;
                if (e_can && !first_found_reg)
                begin
                    first_found_reg <= 1'b1;
                end
                if (e_can && e_st == RS_HIT && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
            end

            if (cmd.issue && pick_found)
            begin
                data_timer_reg  <= delay_reg[pick_st];
                cmd_timer_reg   <= hold_reg;
                busy_act_reg[e_bank] <= 1'b1;
                open_reg[e_bank]     <= 1'b1;
                count_reg       <= count_reg - 1'b1;
            end
        end
    end

    // Payload storage: queue entries, bank counts and rows, scan positions.
    always_ff @(posedge clk)
    begin
        if (cmd.enq && count_reg != Q_FULL)
        begin
            q_bank_reg[count_reg[QW-1:0]]  <= enq_bank;
            q_row_reg[count_reg[QW-1:0]]   <= addr[31:16];
            q_stage_reg[count_reg[QW-1:0]] <= stage;
        end

        if (cmd.dec)
        begin
            for (int b = 0; b < BANK_COUNT; b++)
            begin
                if (busy_act_reg[b] && busy_cnt_reg[b] != '0)
                begin
                    busy_cnt_reg[b] <= busy_cnt_reg[b] - 1'b1;
                end
            end
        end

        if (cmd.scan_step && e_valid && e_can)
        begin
            if (!first_found_reg)
            begin
                first_idx_reg <= idx_reg[QW-1:0];
                first_st_reg  <= e_st;
            end
            if (e_st == RS_HIT && !hit_found_reg)
            begin
                hit_idx_reg <= idx_reg[QW-1:0];
            end
        end

        if (cmd.issue && pick_found)
        begin
            busy_cnt_reg[e_bank] <= pick_cyc;
            open_row_reg[e_bank] <= e_row;
            // Close the gap left by the issued entry; later entries keep their order.
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (QW'(i) >= q_addr)
                begin
                    q_bank_reg[i]  <= q_bank_reg[i+1];
                    q_row_reg[i]   <= q_row_reg[i+1];
                    q_stage_reg[i] <= q_stage_reg[i+1];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            kind_reg        <= KIND_ENQ;
            refused_reg     <= count_reg == Q_FULL;
            bank_id_reg     <= BANKID_W'(enq_bank5);
            row_id_reg      <= addr[31:16];
            mem_stall_reg   <= '0;
            fetch_stall_reg <= '0;
            issued_reg      <= 1'b0;
            last_reg        <= 1'b1;
        end
        else if (cmd.bank_step && status.bank_done)
        begin
            kind_reg        <= KIND_DONE;
            refused_reg     <= 1'b0;
            bank_id_reg     <= BANKID_W'(rd_bank);
            row_id_reg      <= open_row_reg[rd_bank];
            mem_stall_reg   <= '0;
            fetch_stall_reg <= '0;
            issued_reg      <= 1'b0;
            last_reg        <= 1'b0;
        end
        else if (cmd.issue)
        begin
            kind_reg    <= KIND_SUMMARY;
            refused_reg <= 1'b0;
            last_reg    <= 1'b1;
            issued_reg  <= pick_found;
            if (pick_found)
            begin
                bank_id_reg     <= BANKID_W'(e_bank);
                row_id_reg      <= e_row;
                mem_stall_reg   <= e_stage ? pick_cyc : '0;
                fetch_stall_reg <= e_stage ? '0 : pick_cyc;
            end
            else
            begin
                bank_id_reg     <= '0;
                row_id_reg      <= '0;
                mem_stall_reg   <= CYC_W'(any_reg);
                fetch_stall_reg <= CYC_W'(any_reg);
            end
        end
    end

    assign kind        = kind_reg;
    assign refused     = refused_reg;
    assign bank_id     = bank_id_reg;
    assign row_id      = row_id_reg;
    assign mem_stall   = mem_stall_reg;
    assign fetch_stall = fetch_stall_reg;
    assign issued      = issued_reg;
    assign last        = last_reg;

endmodule

// ===== hdl/dram_frfcfs_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// dram_frfcfs_scheduler_core
// FR-FCFS DRAM request scheduler: request queue, per-bank state, bus timers.
// ----------------------------------------------------------------------------
// An enqueue's answer is valid the cycle after acceptance.
// A tick walks the banks, counts down the bus timers, scans the queue and then
// issues; the bank walk and the queue scan share one index counter and one port,
// and the summary is loaded into the output register at the issue step.
// A completion or the summary that waits on the output register stalls the tick.
// One item is in flight at a time. Reset (rst_n, asynchronous, active
// low) empties the queue, idles and closes all banks, clears the bus timers and
// restores the register defaults; no clearing pass is needed.
module dram_frfcfs_scheduler_core
    import dfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int BANK_COUNT  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [ADDR_W-1:0]    addr,
    input  logic                 stage,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic                 refused,
    output logic [BANKID_W-1:0]  bank_id,
    output logic [ROW_W-1:0]     row_id,
    output logic [CYC_W-1:0]     mem_stall,
    output logic [CYC_W-1:0]     fetch_stall,
    output logic                 issued,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CYC_W-1:0]     cfg_data
);

    dfs_cmd_t    cmd;
    dfs_status_t status;

    assign cfg_ready = 1'b1;

    dfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dfs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BANK_COUNT  (BANK_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .addr        (addr),
        .stage       (stage),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .refused     (refused),
        .bank_id     (bank_id),
        .row_id      (row_id),
        .mem_stall   (mem_stall),
        .fetch_stall (fetch_stall),
        .issued      (issued),
        .last        (last)
    );

endmodule

// ===== hdl/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks for the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module dfs_checker
    import dfs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                op,
    input logic                out_valid,
    input logic                out_ready,
    input logic [KIND_W-1:0]   kind,
    input logic                refused,
    input logic                last,
    input logic                issued,
    input logic [CYC_W-1:0]    mem_stall,
    input logic [CYC_W-1:0]    fetch_stall
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("output changed while stalled");

    // A tick transfer starts the bank walk, so no item is taken right after.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_TICK |=> !in_ready)
        else $error("input taken during a tick");

    a_enq_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ENQ |-> last && !issued && mem_stall == '0
                                          && fetch_stall == '0)
        else $error("bad enqueue answer");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> !last && !refused && !issued)
        else $error("bad completion result");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_ENQ || kind == KIND_DONE || kind == KIND_SUMMARY)
        else $error("unknown result kind");

endmodule

bind dram_frfcfs_scheduler_core dfs_checker u_dfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .refused     (refused),
    .last        (last),
    .issued      (issued),
    .mem_stall   (mem_stall),
    .fetch_stall (fetch_stall)
);
